// ===== rtl/core/far_pkg.sv =====
package far_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;
	localparam int SUM_W         = PROD_W + 1;
	localparam int MAG_W         = PROD_W;
	localparam int NUM_W         = 33;
	localparam int DEN_W         = 31;
	localparam int CNT_W         = $clog2(MAG_W);

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MS_X = 2'd0,
		MS_Y = 2'd1,
		MS_C = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     form;
		logic     gcd_init;
		logic     gcd_step;
		logic     div_init;
		logic     div_step;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic zero_case;
		logic gcd_done;
		logic div_last;
	} dp_sts_t;

endpackage

// ===== rtl/core/fraction_arith_reduce_core.sv =====
// Rational add, subtract, multiply and divide of two signed 16-bit fractions, reduced to
// lowest terms with the sign on the numerator and a positive denominator (0/1 for a zero
// result, zero_divisor with zero fields when the raw denominator is zero). One word is
// worked at a time: accept, three products on the shared 16x16 multiplier, form and check
// the raw fraction, then a binary gcd loop of one shift or subtract per cycle until it ends
// (data dependent, on the 32-bit numerator and 31-bit denominator magnitudes) and a
// restoring division of numerator and denominator by the gcd, then into the output
// register. Zero cases skip the gcd and division. A new word is taken while a finished
// result waits in the output register.
module fraction_arith_reduce_core
	import far_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic [1:0]                      cmd,
	input  logic signed [OPERAND_WIDTH-1:0] left_num,
	input  logic signed [OPERAND_WIDTH-1:0] left_den,
	input  logic signed [OPERAND_WIDTH-1:0] right_num,
	input  logic signed [OPERAND_WIDTH-1:0] right_den,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic signed [NUM_W-1:0]         result_num,
	output logic [DEN_W-1:0]                result_den,
	output logic                            zero_divisor
);

	dp_cmd_t dcmd;
	dp_sts_t sts;

	far_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.dcmd         (dcmd)
	);

	far_datapath u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.left_num     (left_num),
		.left_den     (left_den),
		.right_num    (right_num),
		.right_den    (right_den),
		.dcmd         (dcmd),
		.sts          (sts),
		.result_num   (result_num),
		.result_den   (result_den),
		.zero_divisor (zero_divisor)
	);

endmodule

// ===== rtl/core/far_ctrl.sv =====
module far_ctrl
	import far_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	output logic    result_valid,
	input  logic    result_ready,
	input  dp_sts_t sts,
	output dp_cmd_t dcmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MUL_X  = 9'b000000010,
		ST_MUL_Y  = 9'b000000100,
		ST_MUL_C  = 9'b000001000,
		ST_FORM   = 9'b000010000,
		ST_CHECK  = 9'b000100000,
		ST_GCD    = 9'b001000000,
		ST_DIV    = 9'b010000000,
		ST_FINISH = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   result_valid_q;

	always_comb begin
		dcmd       = '0;
		state_d    = state_q;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					dcmd.load = 1'b1;
					state_d   = ST_MUL_X;
				end
			end
			ST_MUL_X: begin
				dcmd.mul_en  = 1'b1;
				dcmd.mul_sel = MS_X;
				state_d      = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				dcmd.mul_en  = 1'b1;
				dcmd.mul_sel = MS_Y;
				state_d      = ST_MUL_C;
			end
			ST_MUL_C: begin
				dcmd.mul_en  = 1'b1;
				dcmd.mul_sel = MS_C;
				state_d      = ST_FORM;
			end
			ST_FORM: begin
				dcmd.form = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.zero_case) begin
					state_d = ST_FINISH;
				end else begin
					dcmd.gcd_init = 1'b1;
					state_d       = ST_GCD;
				end
			end
			ST_GCD: begin
				if (sts.gcd_done) begin
					dcmd.div_init = 1'b1;
					state_d       = ST_DIV;
				end else begin
					dcmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				dcmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!result_valid_q || result_ready) begin
					dcmd.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dcmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

endmodule

// ===== rtl/core/far_datapath.sv =====
module far_datapath
	import far_pkg::*;
(
	input  logic                            clk,
	input  logic [1:0]                      cmd,
	input  logic signed [OPERAND_WIDTH-1:0] left_num,
	input  logic signed [OPERAND_WIDTH-1:0] left_den,
	input  logic signed [OPERAND_WIDTH-1:0] right_num,
	input  logic signed [OPERAND_WIDTH-1:0] right_den,
	input  dp_cmd_t                         dcmd,
	output dp_sts_t                         sts,
	output logic signed [NUM_W-1:0]         result_num,
	output logic [DEN_W-1:0]                result_den,
	output logic                            zero_divisor
);

	cmd_t                            op_q;
	logic signed [OPERAND_WIDTH-1:0] ln_q, ld_q, rn_q, rd_q;
	logic signed [OPERAND_WIDTH-1:0] ma, mb;
	logic signed [PROD_W-1:0]        prod;
	logic signed [PROD_W-1:0]        px_q, py_q, pc_q;
	logic signed [SUM_W-1:0]         px_ext, pc_ext, x_sum;
	logic signed [SUM_W-1:0]         x_q;
	logic signed [PROD_W-1:0]        y_q;
	logic                            x_zero_q, y_zero_q, neg_q;
	logic [SUM_W-1:0]                x_abs;
	logic [MAG_W-1:0]                y_abs;
	logic [MAG_W-1:0]                a_q, b_q, nx_q, ny_q, g_q;
	logic [CNT_W-1:0]                k_q, cnt_q;
	logic [MAG_W-1:0]                qx_q, qy_q;
	logic [MAG_W:0]                  rx_q, ry_q;
	logic [MAG_W:0]                  rx_sh, ry_sh, g_ext;
	logic                            gex, gey;
	logic [NUM_W-1:0]                num_mag;
	logic signed [NUM_W-1:0]         result_num_q;
	logic [DEN_W-1:0]                result_den_q;
	logic                            zero_divisor_q;

	// shared multiplier operand select
	always_comb begin
		ma = ln_q;
		mb = rd_q;
		case (dcmd.mul_sel)
			MS_X: begin
				ma = ln_q;
				mb = (op_q == CMD_MUL) ? rn_q : rd_q;
			end
			MS_Y: begin
				ma = ld_q;
				mb = (op_q == CMD_DIV) ? rn_q : rd_q;
			end
			MS_C: begin
				ma = rn_q;
				mb = ld_q;
			end
			default: begin
				ma = ln_q;
				mb = rd_q;
			end
		endcase
	end

	assign prod = PROD_W'(ma) * PROD_W'(mb);

	assign px_ext = {px_q[PROD_W-1], px_q};
	assign pc_ext = {pc_q[PROD_W-1], pc_q};

	always_comb begin
		case (op_q)
			CMD_ADD: x_sum = px_ext + pc_ext;
			CMD_SUB: x_sum = px_ext - pc_ext;
			default: x_sum = px_ext;
		endcase
	end

	assign x_abs = x_q[SUM_W-1] ? SUM_W'(-x_q) : SUM_W'(x_q);
	assign y_abs = y_q[PROD_W-1] ? MAG_W'(-y_q) : MAG_W'(y_q);

	// restoring division step, both quotients share the divisor
	assign g_ext = {1'b0, g_q};
	assign rx_sh = {rx_q[MAG_W-1:0], qx_q[MAG_W-1]};
	assign ry_sh = {ry_q[MAG_W-1:0], qy_q[MAG_W-1]};
	assign gex   = rx_sh >= g_ext;
	assign gey   = ry_sh >= g_ext;

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			op_q <= cmd_t'(cmd);
			ln_q <= left_num;
			ld_q <= left_den;
			rn_q <= right_num;
			rd_q <= right_den;
		end
		if (dcmd.mul_en) begin
			case (dcmd.mul_sel)
				MS_X:    px_q <= prod;
				MS_Y:    py_q <= prod;
				MS_C:    pc_q <= prod;
				default: px_q <= prod;
			endcase
		end
		if (dcmd.form) begin
			x_q      <= x_sum;
			y_q      <= py_q;
			x_zero_q <= (x_sum == '0);
			y_zero_q <= (py_q == '0);
			neg_q    <= x_sum[SUM_W-1] ^ py_q[PROD_W-1];
		end
		if (dcmd.gcd_init) begin
			a_q  <= x_abs[MAG_W-1:0];
			b_q  <= y_abs;
			nx_q <= x_abs[MAG_W-1:0];
			ny_q <= y_abs;
			k_q  <= '0;
		end else if (dcmd.gcd_step) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= b_q;
				b_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
		if (dcmd.div_init) begin
			g_q   <= a_q << k_q;
			qx_q  <= nx_q;
			qy_q  <= ny_q;
			rx_q  <= '0;
			ry_q  <= '0;
			cnt_q <= '0;
		end else if (dcmd.div_step) begin
			rx_q  <= gex ? rx_sh - g_ext : rx_sh;
			ry_q  <= gey ? ry_sh - g_ext : ry_sh;
			qx_q  <= {qx_q[MAG_W-2:0], gex};
			qy_q  <= {qy_q[MAG_W-2:0], gey};
			cnt_q <= cnt_q + 1'b1;
		end
		if (dcmd.out_load) begin
			zero_divisor_q <= y_zero_q;
			if (y_zero_q) begin
				result_num_q <= '0;
				result_den_q <= '0;
			end else if (x_zero_q) begin
				result_num_q <= '0;
				result_den_q <= DEN_W'(1);
			end else begin
				result_num_q <= neg_q ? -$signed(num_mag) : $signed(num_mag);
				result_den_q <= DEN_W'(qy_q);
			end
		end
	end

	assign num_mag = NUM_W'(qx_q);

	assign sts.zero_case = x_zero_q | y_zero_q;
	assign sts.gcd_done  = (b_q == '0);
	assign sts.div_last  = (cnt_q == CNT_W'(MAG_W - 1));

	assign result_num   = result_num_q;
	assign result_den   = result_den_q;
	assign zero_divisor = zero_divisor_q;

endmodule

// ===== verif/fraction_arith_reduce_core_tb.sv =====
module fraction_arith_reduce_core_tb;
	import far_pkg::*;

	localparam int RANDOM_WORDS = 800;
	localparam int CALM_TAIL    = 80;
	localparam int LONG_HOLD    = 400;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		cmd_t                            op;
		logic signed [OPERAND_WIDTH-1:0] ln;
		logic signed [OPERAND_WIDTH-1:0] ld;
		logic signed [OPERAND_WIDTH-1:0] rn;
		logic signed [OPERAND_WIDTH-1:0] rd;
	} operands_t;

	typedef struct {
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
		logic                    zdiv;
	} fraction_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            item_valid = 1'b0;
	logic                            item_ready;
	logic [1:0]                      cmd = '0;
	logic signed [OPERAND_WIDTH-1:0] left_num = '0;
	logic signed [OPERAND_WIDTH-1:0] left_den = '0;
	logic signed [OPERAND_WIDTH-1:0] right_num = '0;
	logic signed [OPERAND_WIDTH-1:0] right_den = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	logic signed [NUM_W-1:0]         result_num;
	logic [DEN_W-1:0]                result_den;
	logic                            zero_divisor;

	operands_t pending_words[$];
	fraction_t expected_fractions[$];
	logic      word_taken = 1'b0;
	int        errors = 0;
	int        results_seen = 0;
	int        stall_cycles = 0;
	int        gap_left = 0;
	int        hold_left = 0;
	bit        long_hold_done = 0;

	fraction_arith_reduce_core uut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic fraction_t reduce_fraction(operands_t w);
		longint a, b, c, d, x, y, p, q, t;
		logic neg;
		fraction_t r;
		a = longint'(w.ln);
		b = longint'(w.ld);
		c = longint'(w.rn);
		d = longint'(w.rd);
		case (w.op)
			CMD_ADD: begin x = a * d + c * b; y = b * d; end
			CMD_SUB: begin x = a * d - c * b; y = b * d; end
			CMD_MUL: begin x = a * c; y = b * d; end
			default: begin x = a * d; y = b * c; end
		endcase
		r.num = '0;
		r.den = '0;
		r.zdiv = 1'b0;
		if (y == 0) begin
			r.zdiv = 1'b1;
		end else if (x == 0) begin
			r.den = DEN_W'(1);
		end else begin
			neg = (x < 0) != (y < 0);
			if (x < 0) x = -x;
			if (y < 0) y = -y;
			p = x;
			q = y;
			while (q != 0) begin
				t = p % q;
				p = q;
				q = t;
			end
			x = x / p;
			y = y / p;
			r.num = NUM_W'(neg ? -x : x);
			r.den = DEN_W'(y);
		end
		return r;
	endfunction

	function automatic void add_word(cmd_t op, int a, int b, int c, int d);
		operands_t w;
		w.op = op;
		w.ln = OPERAND_WIDTH'(a);
		w.ld = OPERAND_WIDTH'(b);
		w.rn = OPERAND_WIDTH'(c);
		w.rd = OPERAND_WIDTH'(d);
		pending_words.push_back(w);
	endfunction

	function automatic logic signed [OPERAND_WIDTH-1:0] rand_operand();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			return OPERAND_WIDTH'($urandom);
		else if (pick < 9)
			return OPERAND_WIDTH'(int'($urandom_range(0, 40)) - 20);
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return OPERAND_WIDTH'(-1);
			3: return '0;
			default: return OPERAND_WIDTH'(1);
		endcase
	endfunction

	// sample both channels, predict on input accept, check on output accept
	always @(posedge clk) begin
		operands_t w;
		fraction_t e;
		if (arst_n) begin
			word_taken <= item_valid && item_ready;
			if (item_valid && item_ready) begin
				w.op = cmd_t'(cmd);
				w.ln = left_num;
				w.ld = left_den;
				w.rn = right_num;
				w.rd = right_den;
				expected_fractions.push_back(reduce_fraction(w));
			end
			if (result_valid && result_ready) begin
				results_seen++;
				if (expected_fractions.size() == 0) begin
					$error("unexpected word: result_num=%0d result_den=%0d zero_divisor=%0b",
						result_num, result_den, zero_divisor);
					errors++;
				end else begin
					e = expected_fractions.pop_front();
					if (result_num !== e.num) begin
						$error("result_num expected %0d actual %0d", e.num, result_num);
						errors++;
					end
					if (result_den !== e.den) begin
						$error("result_den expected %0d actual %0d", e.den, result_den);
						errors++;
					end
					if (zero_divisor !== e.zdiv) begin
						$error("zero_divisor expected %0b actual %0b", e.zdiv, zero_divisor);
						errors++;
					end
				end
			end
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		operands_t w;
		if (arst_n && !(item_valid && !word_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_words.size() == 0) begin
				item_valid <= 1'b0;
			end else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
				gap_left = $urandom_range(0, 17);
				item_valid <= 1'b0;
			end else begin
				w = pending_words.pop_front();
				item_valid <= 1'b1;
				cmd <= w.op;
				left_num <= w.ln;
				left_den <= w.ld;
				right_num <= w.rn;
				right_den <= w.rd;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 30) begin
				// long hold-off so the block fills up and stalls its input
				long_hold_done = 1;
				hold_left = LONG_HOLD - 1;
				result_ready <= 1'b0;
			end else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 17);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		add_word(CMD_ADD, 1, 2, 1, 3);
		add_word(CMD_SUB, 1, 2, 1, 2);
		add_word(CMD_MUL, 2, 3, 3, 2);
		add_word(CMD_DIV, 1, 2, 1, 4);
		add_word(CMD_ADD, 5, 0, 1, 3);
		add_word(CMD_DIV, 3, 7, 0, 5);
		add_word(CMD_MUL, 0, 0, 1, 1);
		add_word(CMD_DIV, 0, 7, 3, 5);
		add_word(CMD_MUL, -32768, 1, -32768, 1);
		add_word(CMD_MUL, 1, -32768, 1, -32768);
		add_word(CMD_ADD, -32768, -32768, -32768, -32768);
		add_word(CMD_SUB, 32767, -32768, -32768, 32767);
		add_word(CMD_DIV, -32768, 32767, 32767, -32768);
		add_word(CMD_ADD, 1, -3, 1, -6);
		add_word(CMD_MUL, -1, -1, 1, 1);
		add_word(CMD_ADD, 32767, 32767, 32767, 32767);
		add_word(CMD_SUB, -32768, 1, 32767, 1);
		add_word(CMD_MUL, 3, -1, -5, -1);
		add_word(CMD_DIV, 1, 2, -3, 4);
		add_word(CMD_ADD, 32767, 32766, 32765, 32764);
		add_word(CMD_SUB, -32768, 32767, 32767, -32767);
		add_word(CMD_DIV, -32768, -1, -1, 32767);
		for (int i = 0; i < RANDOM_WORDS; i++)
			add_word(cmd_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
				rand_operand(), rand_operand());

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || item_valid)
			@(negedge clk);
		while (expected_fractions.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
